/* src/mer_pkg.sv */
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Shared widths, register indexes and the control/status types that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

   localparam int RADIUS_BITS_DEF = 10;
   localparam int COORD_W         = 12;
   localparam int RADIUS_W        = 10;
   localparam int PIX_W           = 13;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_Y = 2'd3;

   localparam logic [1:0] QUAD_LAST = 2'd3;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_RS_SQ,
      OP_RS_MUL,
      OP_RS_INIT,
      OP_STEP1,
      OP_STEP2,
      OP_R2_SQ,
      OP_R2_MUL,
      OP_R2_INIT,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] quad;
      logic       done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic complete;
      logic region_two;
      logic step_ok;
      logic y_zero;
   } dp_status_type;

endpackage

`default_nettype wire

/* src/mer_controller.sv */
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// Sequences restart, step and region-switch work in the datapath and walks
// the four symmetric pixels (or the done result) out to the response side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mer_controller
   import mer_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_restart,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RS_SQ,
      ST_RS_MUL,
      ST_RS_INIT,
      ST_STEP,
      ST_R2_SQ,
      ST_R2_MUL,
      ST_R2_INIT,
      ST_R2_DECIDE,
      ST_EMIT,
      ST_DONE
   } state_type;

   state_type  state_ff;
   logic [1:0] quad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         quad_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_restart) begin
                     state_ff <= ST_RS_SQ;
                  end else if (status.complete) begin
                     state_ff <= ST_DONE;
                  end else if (status.region_two) begin
                     state_ff <= ST_R2_DECIDE;
                  end else if (status.step_ok) begin
                     state_ff <= ST_STEP;
                  end else begin
                     state_ff <= ST_R2_SQ;
                  end
               end
            end
            ST_RS_SQ:   state_ff <= ST_RS_MUL;
            ST_RS_MUL:  state_ff <= ST_RS_INIT;
            ST_RS_INIT: state_ff <= ST_IDLE;
            ST_R2_SQ:   state_ff <= ST_R2_MUL;
            ST_R2_MUL:  state_ff <= ST_R2_INIT;
            ST_R2_INIT: state_ff <= ST_R2_DECIDE;
            ST_R2_DECIDE: begin
               state_ff <= status.y_zero ? ST_DONE : ST_STEP;
            end
            ST_STEP: begin
               state_ff <= ST_EMIT;
               quad_ff  <= '0;
            end
            ST_EMIT: begin
               if (!rsp_stall) begin
                  if (quad_ff == QUAD_LAST) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     quad_ff <= quad_ff + 2'd1;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.quad = quad_ff;
      cmd.done = (state_ff == ST_DONE);
      unique case (state_ff)
         ST_RS_SQ:     cmd.op = OP_RS_SQ;
         ST_RS_MUL:    cmd.op = OP_RS_MUL;
         ST_RS_INIT:   cmd.op = OP_RS_INIT;
         ST_R2_SQ:     cmd.op = OP_R2_SQ;
         ST_R2_MUL:    cmd.op = OP_R2_MUL;
         ST_R2_INIT:   cmd.op = OP_R2_INIT;
         ST_R2_DECIDE: cmd.op = status.y_zero ? OP_FINISH : OP_NOP;
         ST_STEP:      cmd.op = status.region_two ? OP_STEP2 : OP_STEP1;
         default:      cmd.op = OP_NOP;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT) || (state_ff == ST_DONE);

endmodule

`default_nettype wire

/* src/mer_datapath.sv */
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Holds the step position, the running products and the scaled decision
// value, with two shared multipliers for the start values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mer_datapath
   import mer_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF
)(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ctrl_cmd_type               cmd,
   output dp_status_type                   status,
   input  wire logic signed [COORD_W-1:0]  center_x,
   input  wire logic signed [COORD_W-1:0]  center_y,
   input  wire logic        [RADIUS_W-1:0] radius_x,
   input  wire logic        [RADIUS_W-1:0] radius_y,
   output logic signed      [PIX_W-1:0]    pixel_x,
   output logic signed      [PIX_W-1:0]    pixel_y,
   output logic                            last_of_step,
   output logic                            finished
);

   localparam int R      = RADIUS_BITS;
   localparam int SQ_W   = 2 * R;
   localparam int MA_W   = 2 * R;
   localparam int MB_W   = 2 * R + 4;
   localparam int PROD_W = MA_W + MB_W;
   localparam int PQ_W   = 3 * R + 2;
   localparam int DEC_W  = (4 * R + 8 > 64) ? 64 : 4 * R + 8;

   logic [R-1:0]      ry_ff;
   logic [SQ_W-1:0]   rx2_ff, ry2_ff;
   logic [4*R-1:0]    rx2ry2_ff;
   logic [PROD_W-1:0] p0_ff, p1_ff;
   logic [R:0]        x_ff;
   logic [R-1:0]      y_ff;
   logic [PQ_W-1:0]   px_ff, py_ff;
   logic [DEC_W-1:0]  dec_ff;
   logic              region_two_ff, complete_ff;

   logic [R-1:0]      lat_rx, lat_ry;
   logic [R+1:0]      t_val;
   logic [R-1:0]      u_val;
   logic [MA_W-1:0]   ma0, ma1;
   logic [MB_W-1:0]   mb0, mb1;
   logic [PROD_W-1:0] prod0, prod1;
   logic [PQ_W-1:0]   px_inc, py_dec;
   logic [DEC_W-1:0]  term_px, term_py, term_ry2, term_rx2;
   logic              dec_neg, dec_zero;

   assign lat_rx = R'(radius_x);
   assign lat_ry = R'(radius_y);
   assign t_val  = {x_ff, 1'b1};
   assign u_val  = (y_ff == '0) ? R'(1) : y_ff - R'(1);

   // Operand selection for the two shared multipliers.
   always_comb begin
      ma0 = '0;
      mb0 = '0;
      ma1 = '0;
      mb1 = '0;
      case (cmd.op)
         OP_RS_SQ: begin
            ma0 = MA_W'(lat_rx);
            mb0 = MB_W'(lat_rx);
            ma1 = MA_W'(lat_ry);
            mb1 = MB_W'(lat_ry);
         end
         OP_RS_MUL: begin
            ma0 = p0_ff[SQ_W-1:0];
            mb0 = MB_W'(ry_ff);
            ma1 = p0_ff[SQ_W-1:0];
            mb1 = MB_W'(p1_ff[SQ_W-1:0]);
         end
         OP_R2_SQ: begin
            ma0 = MA_W'(t_val);
            mb0 = MB_W'(t_val);
            ma1 = MA_W'(u_val);
            mb1 = MB_W'(u_val);
         end
         OP_R2_MUL: begin
            ma0 = ry2_ff;
            mb0 = p0_ff[MB_W-1:0];
            ma1 = rx2_ff;
            mb1 = MB_W'(p1_ff[SQ_W-1:0]);
         end
         default: begin
         end
      endcase
   end

   assign prod0 = PROD_W'(ma0) * PROD_W'(mb0);
   assign prod1 = PROD_W'(ma1) * PROD_W'(mb1);

   // The running products track 2*ry^2*x and 2*rx^2*y across both regions.
   assign px_inc   = px_ff + PQ_W'({ry2_ff, 1'b0});
   assign py_dec   = py_ff - PQ_W'({rx2_ff, 1'b0});
   assign term_px  = DEC_W'(px_inc) << 2;
   assign term_py  = DEC_W'(py_dec) << 2;
   assign term_ry2 = DEC_W'(ry2_ff) << 2;
   assign term_rx2 = DEC_W'(rx2_ff) << 2;
   assign dec_neg  = dec_ff[DEC_W-1];
   assign dec_zero = (dec_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff          <= '0;
         y_ff          <= '0;
         dec_ff        <= '0;
         region_two_ff <= 1'b0;
         complete_ff   <= 1'b1;
         ry_ff         <= '0;
      end else begin
         case (cmd.op)
            OP_RS_SQ: begin
               ry_ff         <= lat_ry;
               x_ff          <= '0;
               y_ff          <= lat_ry;
               region_two_ff <= 1'b0;
               complete_ff   <= (lat_ry == '0);
               p0_ff         <= prod0;
               p1_ff         <= prod1;
            end
            OP_RS_MUL: begin
               rx2_ff <= p0_ff[SQ_W-1:0];
               ry2_ff <= p1_ff[SQ_W-1:0];
               p0_ff  <= prod0;
               p1_ff  <= prod1;
            end
            OP_RS_INIT: begin
               px_ff     <= '0;
               py_ff     <= PQ_W'(p0_ff) << 1;
               rx2ry2_ff <= p1_ff[4*R-1:0];
               dec_ff    <= term_ry2 - (DEC_W'(p0_ff) << 2) + DEC_W'(rx2_ff);
            end
            OP_STEP1: begin
               x_ff  <= x_ff + (R+1)'(1);
               px_ff <= px_inc;
               if (dec_neg) begin
                  dec_ff <= dec_ff + term_px + term_ry2;
               end else begin
                  y_ff   <= y_ff - R'(1);
                  py_ff  <= py_dec;
                  dec_ff <= dec_ff + term_px - term_py + term_ry2;
               end
            end
            OP_STEP2: begin
               y_ff  <= y_ff - R'(1);
               py_ff <= py_dec;
               if (dec_neg || dec_zero) begin
                  x_ff   <= x_ff + (R+1)'(1);
                  px_ff  <= px_inc;
                  dec_ff <= dec_ff + term_px - term_py + term_rx2;
               end else begin
                  dec_ff <= dec_ff + term_rx2 - term_py;
               end
            end
            OP_R2_SQ: begin
               region_two_ff <= 1'b1;
               p0_ff         <= prod0;
               p1_ff         <= prod1;
            end
            OP_R2_MUL: begin
               p0_ff <= prod0;
               p1_ff <= prod1;
            end
            OP_R2_INIT: begin
               dec_ff <= DEC_W'(p0_ff) + (DEC_W'(p1_ff) << 2)
                         - (DEC_W'(rx2ry2_ff) << 2);
            end
            OP_FINISH: complete_ff <= 1'b1;
            default: begin
            end
         endcase
      end
   end

   assign status.complete   = complete_ff;
   assign status.region_two = region_two_ff;
   assign status.step_ok    = (px_ff <= py_ff);
   assign status.y_zero     = (y_ff == '0);

   // Pixel order within a step: bit 0 of the quadrant mirrors x, bit 1 mirrors y.
   logic [PIX_W-1:0] cx_ext, cy_ext, x_off, y_off, pix_x, pix_y;

   assign cx_ext = PIX_W'(center_x);
   assign cy_ext = PIX_W'(center_y);
   assign x_off  = PIX_W'(x_ff);
   assign y_off  = PIX_W'(y_ff);
   assign pix_x  = cmd.quad[0] ? cx_ext - x_off : cx_ext + x_off;
   assign pix_y  = cmd.quad[1] ? cy_ext - y_off : cy_ext + y_off;

   assign pixel_x      = cmd.done ? '0 : pix_x;
   assign pixel_y      = cmd.done ? '0 : pix_y;
   assign last_of_step = cmd.done || (cmd.quad == QUAD_LAST);
   assign finished     = cmd.done;

endmodule

`default_nettype wire

/* src/midpoint_ellipse_rasterizer_core.sv */
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer core
// Steps a midpoint ellipse one request at a time and returns the four
// mirrored pixels of each step, or a single done result at the end.
// ---------------------------------------------------------------------------
//  Channel    Direction  Handshake            Payload
//  req_*      in         req_valid/req_stall  restart
//  rsp_*      out        rsp_valid/rsp_stall  pixel_x, pixel_y, last_of_step,
//                                             finished
//  csr_*      in         csr_write_en         csr_index, csr_write_data
//
// A restart request is accepted and then works through the squared radii, their
// cross products and the start value. A region-one step is followed by its four
// responses, a region-two step first passes a decide state, and the switch into
// region two first computes its start value. A done result follows the decide
// state when it ends a curve in region two. Synchronous reset leaves no ellipse
// active. A stalled response holds the block; one request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer_core
   import mer_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF
)(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_restart,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [PIX_W-1:0]           rsp_pixel_x,
   output logic signed [PIX_W-1:0]           rsp_pixel_y,
   output logic                              rsp_last_of_step,
   output logic                              rsp_finished,
   input  wire logic                         csr_write_en,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_write_data
);

   logic signed [COORD_W-1:0]  center_x_ff, center_y_ff;
   logic        [RADIUS_W-1:0] radius_x_ff, radius_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_x_ff <= '0;
         radius_y_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= COORD_W'(csr_write_data);
            CSR_CENTER_Y: center_y_ff <= COORD_W'(csr_write_data);
            CSR_RADIUS_X: radius_x_ff <= csr_write_data[RADIUS_W-1:0];
            CSR_RADIUS_Y: radius_y_ff <= csr_write_data[RADIUS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mer_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   mer_datapath #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .radius_x     (radius_x_ff),
      .radius_y     (radius_y_ff),
      .pixel_x      (rsp_pixel_x),
      .pixel_y      (rsp_pixel_y),
      .last_of_step (rsp_last_of_step),
      .finished     (rsp_finished)
   );

endmodule

`default_nettype wire

/* src/mer_checker.sv */
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer checker
// Port-level checks on request/response ordering, bound to the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mer_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_restart,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [12:0] rsp_pixel_x,
   input wire logic [12:0] rsp_pixel_y,
   input wire logic        rsp_last_of_step,
   input wire logic        rsp_finished
);

   // A restart request never produces a response.
   a_restart_silent : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_restart) |=> !rsp_valid)
      else $error("response after restart request");

   // The done result is a single last item with zero coordinates.
   a_done_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |->
         (rsp_last_of_step && rsp_pixel_x == 13'd0 && rsp_pixel_y == 13'd0))
      else $error("malformed done result");

   // No new request is taken while responses are outstanding.
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while responding");

   // The last item of a step closes the burst.
   a_burst_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_step) |=> !rsp_valid)
      else $error("response after last item");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_last_of_step) && $stable(rsp_finished)))
      else $error("stalled response changed");

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker u_checker (.*);

`default_nettype wire

/* tb/midpoint_ellipse_rasterizer_core_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer core testbench
// Programs centre and radii, sends restart and advance requests, and checks
// every returned pixel against an algorithmic model of the midpoint ellipse
// walk, under random idling on both channels and then with none.
// ---------------------------------------------------------------------------

module midpoint_ellipse_rasterizer_core_test
   import mer_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int ITEMS_PER_MODE = 40;

   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      logic             last;
      logic             fin;
   } pixel_type;

   localparam pixel_type DONE_PIXEL = '{px: '0, py: '0, last: 1'b1, fin: 1'b1};

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      bit                    restart;
      bit                    typed_done;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } stim_row_type;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_restart    = 1'b0;
   logic                    rsp_stall      = 1'b0;
   logic                    csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index      = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;
   logic                    req_stall;
   logic                    rsp_valid;
   logic signed [PIX_W-1:0] rsp_pixel_x;
   logic signed [PIX_W-1:0] rsp_pixel_y;
   logic                    rsp_last_of_step;
   logic                    rsp_finished;

   int sender_idle_pct = 23;
   int recv_idle_pct   = 53;
   int mismatches      = 0;
   int requests_sent   = 0;
   int restarts_sent   = 0;
   int results_checked = 0;
   int done_results    = 0;

   pixel_type pending_pixels [$];

   // Register shadow and ellipse walk state.
   longint cfg_cx, cfg_cy, cfg_rx, cfg_ry;
   longint ell_x, ell_y, ell_dec, ell_rx, ell_ry;
   bit     ell_region2, ell_complete;

   stim_row_type stim_table [32];

   midpoint_ellipse_rasterizer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_finished     (rsp_finished),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic stim_row_type req_row(input bit restart, input bit typed_done);
      stim_row_type row;
      row = '{ROW_REQUEST, restart, typed_done, '0, '0};
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{ROW_CSR, 1'b0, 1'b0, idx, data};
      return row;
   endfunction

   function automatic logic [RADIUS_W-1:0] pick_radius();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return RADIUS_W'($urandom_range(512, 1023));
      if (roll < 14) return '0;
      return RADIUS_W'($urandom_range(1, 7));
   endfunction

   // Order within a step: (+x,+y), (-x,+y), (+x,-y), (-x,-y).
   function automatic void mirror_pixels(output pixel_type pix [4]);
      longint sx, sy;
      for (int k = 0; k < 4; k++) begin
         sx = (k % 2 == 1) ? -ell_x : ell_x;
         sy = (k >= 2) ? -ell_y : ell_y;
         pix[k].px   = PIX_W'(cfg_cx + sx);
         pix[k].py   = PIX_W'(cfg_cy + sy);
         pix[k].last = (k == 3);
         pix[k].fin  = 1'b0;
      end
   endfunction

   // Decision values are kept scaled by four so that the half terms are exact.
   function automatic int trace_ellipse(input bit restart, output pixel_type pix [4]);
      longint rx2, ry2, t, dy;
      if (restart) begin
         ell_rx       = cfg_rx;
         ell_ry       = cfg_ry;
         ell_x        = 0;
         ell_y        = ell_ry;
         ell_region2  = 1'b0;
         ell_dec      = 4 * ell_ry * ell_ry - 4 * ell_rx * ell_rx * ell_ry
                        + ell_rx * ell_rx;
         ell_complete = (ell_ry == 0);
         return 0;
      end
      if (ell_complete) begin
         pix[0] = DONE_PIXEL;
         return 1;
      end
      rx2 = ell_rx * ell_rx;
      ry2 = ell_ry * ell_ry;
      if (!ell_region2) begin
         if (ry2 * ell_x <= rx2 * ell_y) begin
            ell_x++;
            if (ell_dec < 0) begin
               ell_dec += 8 * ry2 * ell_x + 4 * ry2;
            end else begin
               ell_y--;
               ell_dec += 8 * ry2 * ell_x - 8 * rx2 * ell_y + 4 * ry2;
            end
            mirror_pixels(pix);
            return 4;
         end
         // The slope has passed -1: load the region-two start value and carry on.
         ell_region2 = 1'b1;
         t  = 2 * ell_x + 1;
         dy = ell_y - 1;
         if (dy < 0) dy = -dy;
         ell_dec = ry2 * t * t + 4 * rx2 * dy * dy - 4 * rx2 * ry2;
      end
      if (ell_y <= 0) begin
         ell_complete = 1'b1;
         pix[0] = DONE_PIXEL;
         return 1;
      end
      if (ell_dec <= 0) begin
         ell_x++;
         ell_y--;
         ell_dec += 8 * ry2 * ell_x - 8 * rx2 * ell_y + 4 * rx2;
      end else begin
         ell_y--;
         ell_dec += 4 * rx2 - 8 * rx2 * ell_y;
      end
      mirror_pixels(pix);
      return 4;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // without touching req_valid, so back-to-back requests keep it high.
   task automatic send_request(input bit restart, input bit typed_done);
      pixel_type pix [4];
      int        n;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      n = trace_ellipse(restart, pix);
      if (typed_done) begin
         pending_pixels.push_back(DONE_PIXEL);
      end else begin
         for (int k = 0; k < n; k++) pending_pixels.push_back(pix[k]);
      end
      requests_sent++;
      if (restart) restarts_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data, input bit last);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_CENTER_X: cfg_cx = $signed(data);
         CSR_CENTER_Y: cfg_cy = $signed(data);
         CSR_RADIUS_X: cfg_rx = data[RADIUS_W-1:0];
         CSR_RADIUS_Y: cfg_ry = data[RADIUS_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      if (last) csr_write_en <= 1'b0;
   endtask

   // A restart returns no results and may still be busy when the queue empties,
   // hence the extra cycles before any register write.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void check_field(input string field, input logic [PIX_W-1:0] want,
                                       input logic [PIX_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, $signed(want),
                  $signed(got));
         mismatches++;
      end
   endfunction

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: expected no result, got (%0d, %0d)", $time,
                     rsp_pixel_x, rsp_pixel_y);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_x", want.px, rsp_pixel_x);
            check_field("pixel_y", want.py, rsp_pixel_y);
            check_field("last_of_step", PIX_W'(want.last), PIX_W'(rsp_last_of_step));
            check_field("finished", PIX_W'(want.fin), PIX_W'(rsp_finished));
            results_checked++;
            if (rsp_finished) done_results++;
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: nothing moved on either channel for %0d cycles", $time,
               WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int mode_items, steps, step_budget, extra_done;
      cfg_cx       = 0;
      cfg_cy       = 0;
      cfg_rx       = 0;
      cfg_ry       = 0;
      ell_x        = 0;
      ell_y        = 0;
      ell_dec      = 0;
      ell_rx       = 0;
      ell_ry       = 0;
      ell_region2  = 1'b0;
      ell_complete = 1'b1;

      stim_table = '{
         req_row(1'b0, 1'b1),             // advance with no ellipse active
         req_row(1'b1, 1'b0),             // restart with zero radii
         req_row(1'b0, 1'b1),             // zero vertical radius finishes at once
         csr_row(CSR_CENTER_X, 12'h7FF),
         csr_row(CSR_CENTER_Y, 12'h800),
         csr_row(CSR_RADIUS_X, 12'd3),
         csr_row(CSR_RADIUS_Y, 12'd2),
         req_row(1'b1, 1'b0),
         req_row(1'b0, 1'b0),
         req_row(1'b0, 1'b0),
         req_row(1'b0, 1'b0),
         req_row(1'b0, 1'b1),             // region switch straight into done
         req_row(1'b0, 1'b1),
         csr_row(CSR_RADIUS_X, 12'd0),
         csr_row(CSR_RADIUS_Y, 12'h3FF),
         req_row(1'b1, 1'b0),
         req_row(1'b0, 1'b0),
         req_row(1'b0, 1'b0),             // switch then first region-two step
         csr_row(CSR_CENTER_X, 12'h800),  // centre moves under an active curve
         csr_row(CSR_CENTER_Y, 12'h7FF),
         req_row(1'b0, 1'b0),
         csr_row(CSR_RADIUS_X, 12'hFFF),  // spare data bits above the radius
         csr_row(CSR_RADIUS_Y, 12'h3FF),
         req_row(1'b1, 1'b0),
         req_row(1'b0, 1'b0),
         req_row(1'b0, 1'b0),
         req_row(1'b0, 1'b0),
         csr_row(CSR_RADIUS_X, 12'd1),
         csr_row(CSR_RADIUS_Y, 12'd1),
         req_row(1'b1, 1'b0),             // restart in the middle of a curve
         req_row(1'b0, 1'b0),
         req_row(1'b0, 1'b1)
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR) begin
            if (i == 0 || stim_table[i-1].kind != ROW_CSR) settle_block();
            write_csr(stim_table[i].index, stim_table[i].data,
                      i == $size(stim_table) - 1 || stim_table[i+1].kind != ROW_CSR);
         end else begin
            send_request(stim_table[i].restart, stim_table[i].typed_done);
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin sender_idle_pct = 23; recv_idle_pct = 53; end
            1: begin sender_idle_pct = 53; recv_idle_pct = 23; end
            default: begin sender_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         mode_items = 0;
         while (mode_items < ITEMS_PER_MODE) begin
            if ($urandom_range(0, 3) != 0) begin
               settle_block();
               write_csr(CSR_CENTER_X, CSR_DATA_W'($urandom), 1'b0);
               write_csr(CSR_CENTER_Y, CSR_DATA_W'($urandom), 1'b0);
               write_csr(CSR_RADIUS_X, {2'($urandom), pick_radius()}, 1'b0);
               write_csr(CSR_RADIUS_Y, {2'($urandom), pick_radius()}, 1'b1);
            end
            send_request(1'b1, 1'b0);
            mode_items++;
            // Large curves take thousands of steps, so only their start is walked.
            step_budget = (ell_rx > 64 || ell_ry > 64) ? $urandom_range(1, 6) : 1000;
            if ($urandom_range(0, 5) == 0) step_budget = $urandom_range(0, 4);
            extra_done = $urandom_range(1, 3);
            steps = 0;
            while (steps < step_budget && extra_done > 0) begin
               if ($urandom_range(0, 19) == 0) begin
                  settle_block();
                  write_csr(CSR_CENTER_X, CSR_DATA_W'($urandom), 1'b0);
                  write_csr(CSR_CENTER_Y, CSR_DATA_W'($urandom), 1'b1);
               end
               send_request(1'b0, 1'b0);
               steps++;
               mode_items++;
               if (ell_complete) extra_done--;
            end
         end
      end

      settle_block();
      $display("Ran %0d requests (%0d restarts) over three idling patterns.",
               requests_sent, restarts_sent);
      $display("Checked %0d results, %0d of them end-of-curve markers.",
               results_checked, done_results);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
